// File: rtl/core/fbaw_pkg.sv
`timescale 1ns / 1ps
package fbaw_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 16;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int WORD_W     = NUM_CH * CH_W;
  localparam int LIN_W      = 2 * CFG_W;
  localparam int IDX_W      = 16;
  localparam int SUM_W      = 2 * CH_W;
  localparam int IN_DATA_W  = 2 * POS_W + WORD_W;
  localparam int OUT_DATA_W = IDX_W + WORD_W;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE = 2'd2;

  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 9'd256;

  localparam logic [CH_W-1:0]   CH_MAX     = 8'hFF;
  localparam logic [WORD_W-1:0] CLEAR_WORD = 32'hFF00_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_MIX,
    ST_DIV,
    ST_CLEAR,
    ST_FINISH
  } fbaw_state_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // floor(v / 255), exact for v below 65280
  function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, v} + {9'b0, v[SUM_W-1:CH_W]} + 17'd1;
    return t[SUM_W-1:CH_W];
  endfunction

endpackage

// File: rtl/core/fbaw_ram.sv
`timescale 1ns / 1ps
module fbaw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/framebuffer_alpha_blend_writer_core.sv
`timescale 1ns / 1ps
// Path from input beat to result beat: an unblended or clipped draw goes through calc and finish,
// a blended draw through calc, frame store read port, multiply, divide and finish,
// a clear through calc, width*height clear writes (one frame store write per cycle) and finish.
// One item at a time; the next beat is taken the cycle after the result is registered.
// Reset (synchronous, rst_n low): registers to 256 x 256, blending off, pipeline idle.
// The frame store itself is not reset and holds undefined data until written or cleared.
module framebuffer_alpha_blend_writer_core #(
  parameter int MAX_WIDTH  = fbaw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fbaw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pos_x, pos_y, src_red, src_green, src_blue, src_alpha
  input  logic [fbaw_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_index, out_red, out_green, out_blue, out_alpha
  output logic [fbaw_pkg::OUT_DATA_W-1:0]     out_tdata,
  // wrote_pixel, cleared
  output logic [fbaw_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                                cfg_we,
  input  logic [fbaw_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [fbaw_pkg::CFG_W-1:0]          cfg_wdata
);
  import fbaw_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fbaw_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  width_r, height_r;
  logic              blend_r;
  logic [CFG_W-1:0]  w_eff, h_eff;

  logic              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  pixel_t            src_r, src_nxt;
  logic [LIN_W-1:0]  addr_r, addr_nxt;
  logic [LIN_W-1:0]  n_r, n_nxt;
  logic [LIN_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_r, sum_nxt;
  pixel_t            res_r, res_nxt;
  logic              wrote_r, wrote_nxt;
  logic              clr_r, clr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic              out_free;
  logic              clip;
  logic [LIN_W-1:0]  lin_addr;
  logic [LIN_W-1:0]  lin_cnt;

  logic              mem_we;
  logic [LIN_W-1:0]  mem_waddr_lin;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  pixel_t            dst;
  logic [AW+LIN_W-1:0] waddr_ext, raddr_ext;

  assign w_eff = (32'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r;
  assign h_eff = (32'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r;

  assign clip     = (x_r >= {7'b0, w_eff}) || (y_r >= {7'b0, h_eff});
  assign lin_addr = ({9'b0, y_r[CFG_W-1:0]} * {9'b0, w_eff}) + {9'b0, x_r[CFG_W-1:0]};
  assign lin_cnt  = {9'b0, w_eff} * {9'b0, h_eff};

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign waddr_ext = {{AW{1'b0}}, mem_waddr_lin};
  assign raddr_ext = {{AW{1'b0}}, addr_r};
  assign mem_waddr = waddr_ext[AW-1:0];
  assign mem_raddr = raddr_ext[AW-1:0];
  assign dst       = mem_rdata;

  fbaw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      blend_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        CFG_BLEND_ENABLE: blend_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    src_r      <= src_nxt;
    addr_r     <= addr_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    wrote_r    <= wrote_nxt;
    clr_r      <= clr_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    src_nxt       = src_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    wrote_nxt     = wrote_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mem_we        = 1'b0;
    mem_waddr_lin = addr_r;
    mem_wdata     = res_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          x_nxt     = in_tdata[POS_W-1:0];
          y_nxt     = in_tdata[2*POS_W-1:POS_W];
          src_nxt   = in_tdata[IN_DATA_W-1:2*POS_W];
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        addr_nxt = lin_addr;
        n_nxt    = lin_cnt;
        cnt_nxt  = '0;
        if (cmd_r == CMD_CLEAR) begin
          res_nxt   = CLEAR_WORD;
          wrote_nxt = 1'b0;
          clr_nxt   = 1'b1;
          addr_nxt  = '0;
          state_nxt = ST_CLEAR;
        end else if (clip) begin
          res_nxt   = '0;
          wrote_nxt = 1'b0;
          clr_nxt   = 1'b0;
          addr_nxt  = '0;
          state_nxt = ST_FINISH;
        end else if (blend_r) begin
          wrote_nxt = 1'b1;
          clr_nxt   = 1'b0;
          state_nxt = ST_READ;
        end else begin
          res_nxt   = src_r;
          wrote_nxt = 1'b1;
          clr_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        for (int c = 0; c < NUM_CH; c++) begin
          sum_nxt[c] = (SUM_W'(src_r[c]) * SUM_W'(src_r[NUM_CH-1]))
                     + (SUM_W'(dst[c]) * SUM_W'(CH_MAX - src_r[NUM_CH-1]));
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        for (int c = 0; c < NUM_CH; c++) begin
          res_nxt[c] = div255(sum_r[c]);
        end
        state_nxt = ST_FINISH;
      end
      ST_CLEAR: begin
        if (cnt_r == n_r) begin
          state_nxt = ST_FINISH;
        end else begin
          mem_we        = 1'b1;
          mem_waddr_lin = cnt_r;
          mem_wdata     = CLEAR_WORD;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          mem_we        = wrote_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_r, addr_r[IDX_W-1:0]};
          out_user_nxt  = {clr_r, wrote_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: test/framebuffer_alpha_blend_writer_core_tb.sv
`timescale 1ns / 1ps
module framebuffer_alpha_blend_writer_core_tb;
  import fbaw_pkg::*;

  localparam int FB_MAX_W     = DEF_MAX_WIDTH;
  localparam int FB_MAX_H     = DEF_MAX_HEIGHT;
  localparam int FB_DEPTH     = FB_MAX_W * FB_MAX_H;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CLEAR_CAP    = 1024;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic            cmd;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_cmd_t;

  typedef struct packed {
    logic            wrote;
    logic            cleared;
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = CMD_DRAW;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [CFG_W-1:0] frame_w = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] frame_h = RST_FRAME_HEIGHT;
  logic blend_on = 1'b0;
  logic [WORD_W-1:0] frame_copy [0:FB_DEPTH-1];

  pixel_cmd_t pixel_cmds[$];
  pixel_write_t expected_writes[$];
  pixel_cmd_t cur_cmd;
  int errors = 0;
  int sent_count = 0;
  int write_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  framebuffer_alpha_blend_writer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [CH_W-1:0] mix8(input logic [CH_W-1:0] s, input logic [CH_W-1:0] d,
                                           input logic [CH_W-1:0] a);
    int unsigned t;
    t = (32'(s) * 32'(a) + 32'(d) * (32'd255 - 32'(a))) / 32'd255;
    return t[CH_W-1:0];
  endfunction

  function automatic int eff_size(input logic [CFG_W-1:0] v, input int max_v);
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  function automatic pixel_write_t store_pixel_cmd(input pixel_cmd_t c);
    pixel_write_t res;
    int unsigned w, h, addr;
    logic [WORD_W-1:0] d;
    logic [CH_W-1:0] r, g, b, a;
    w = eff_size(frame_w, FB_MAX_W);
    h = eff_size(frame_h, FB_MAX_H);
    res = '0;
    if (c.cmd == CMD_CLEAR) begin
      for (int i = 0; i < int'(w * h) && i < FB_DEPTH; i++) frame_copy[i] = CLEAR_WORD;
      res.cleared = 1'b1;
      res.alpha = CH_MAX;
      return res;
    end
    if (c.x >= w || c.y >= h) return res;
    addr = c.y * w + c.x;
    r = c.red;
    g = c.green;
    b = c.blue;
    a = c.alpha;
    if (blend_on) begin
      d = frame_copy[addr];
      r = mix8(r, d[7:0], a);
      g = mix8(g, d[15:8], a);
      b = mix8(b, d[23:16], a);
      a = mix8(a, d[31:24], a);
    end
    frame_copy[addr] = {a, b, g, r};
    res.wrote = 1'b1;
    res.index = addr[IDX_W-1:0];
    res.red = r;
    res.green = g;
    res.blue = b;
    res.alpha = a;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_writes.push_back(store_pixel_cmd(cur_cmd));
        sent_count++;
      end
      if (pixel_cmds.size() > 0 &&
          ((sent_count >= 700 && sent_count < 1000) || $urandom_range(99) >= 30)) begin
        cur_cmd = pixel_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {cur_cmd.alpha, cur_cmd.blue, cur_cmd.green, cur_cmd.red,
                     cur_cmd.y, cur_cmd.x};
        in_tuser <= cur_cmd.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    pixel_write_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t unexpected beat: expected none, got user %0h data %0h",
                   $time, out_tuser, out_tdata);
          errors++;
        end else begin
          want = expected_writes.pop_front();
          check_field("wrote_pixel", 32'(want.wrote), 32'(out_tuser[0]));
          check_field("cleared", 32'(want.cleared), 32'(out_tuser[1]));
          check_field("pixel_index", 32'(want.index), 32'(out_tdata[15:0]));
          check_field("out_red", 32'(want.red), 32'(out_tdata[23:16]));
          check_field("out_green", 32'(want.green), 32'(out_tdata[31:24]));
          check_field("out_blue", 32'(want.blue), 32'(out_tdata[39:32]));
          check_field("out_alpha", 32'(want.alpha), 32'(out_tdata[47:40]));
        end
        write_count++;
      end
      // hold off long enough for the input side to back up
      if (hold_left == 0 && holds_done < 2 && pixel_cmds.size() >= 8 &&
          write_count >= (holds_done == 0 ? 250 : 1300)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (write_count >= 700 && write_count < 1000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_cmds.size() != 0 || in_tvalid || expected_writes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = val;
      CFG_FRAME_HEIGHT: frame_h = val;
      CFG_BLEND_ENABLE: blend_on = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input logic en);
    logic [CFG_W-1:0] word;
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w[CFG_W-1:0]);
    write_reg(CFG_FRAME_HEIGHT, h[CFG_W-1:0]);
    word = CFG_W'($urandom);
    word[0] = en;
    write_reg(CFG_BLEND_ENABLE, word);
    @(negedge clk);
  endtask

  task automatic push_cmd(input logic cmd, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                          input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                          input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
    pixel_cmds.push_back({cmd, x, y, r, g, b, a});
  endtask

  initial begin
    int w, h, weff, heff, len, sel, rand_items;
    logic [POS_W-1:0] x, y;
    logic [CH_W-1:0] a;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset frame, blending off; full clear before any blend reads the store
    push_cmd(CMD_DRAW, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_DRAW, 16'd255, 16'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_DRAW, 16'd256, 16'd0, 8'h12, 8'h34, 8'h56, 8'h78);
    push_cmd(CMD_DRAW, 16'd0, 16'd256, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
    push_cmd(CMD_DRAW, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    set_frame(256, 256, 1'b1);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
             CH_W'($urandom_range(255)), 8'h00);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
             CH_W'($urandom_range(255)), 8'hFF);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
             CH_W'($urandom_range(255)), 8'd128);
    push_cmd(CMD_DRAW, 16'd255, 16'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(CMD_DRAW, 16'd255, 16'd255, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_DRAW, 16'd300, 16'd5, 8'h11, 8'h22, 8'h33, 8'h44);

    // oversized frame acts as the full store
    set_frame(511, 300, 1'b1);
    push_cmd(CMD_DRAW, 16'd255, 16'd255, 8'h80, 8'h40, 8'h20, CH_W'($urandom_range(255)));
    push_cmd(CMD_DRAW, 16'd256, 16'd0, 8'h01, 8'h02, 8'h03, 8'h04);
    push_cmd(CMD_DRAW, 16'd0, 16'd256, 8'h05, 8'h06, 8'h07, 8'h08);

    // zero width, then zero height
    set_frame(0, 256, 1'b0);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, 8'hAA, 8'h55, 8'hAA, 8'h55);
    push_cmd(CMD_CLEAR, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    set_frame(256, 0, 1'b1);
    push_cmd(CMD_CLEAR, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, 8'h55, 8'hAA, 8'h55, 8'hAA);

    // single pixel frame
    set_frame(1, 1, 1'b1);
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    @(negedge clk);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, 8'hC0, 8'h30, 8'h0C, 8'd77);
    push_cmd(CMD_DRAW, 16'd1, 16'd0, 8'hC0, 8'h30, 8'h0C, 8'd77);
    push_cmd(CMD_DRAW, 16'd0, 16'd1, 8'hC0, 8'h30, 8'h0C, 8'd77);
    push_cmd(CMD_CLEAR, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(CMD_DRAW, 16'd0, 16'd0, 8'h3F, 8'hCF, 8'hF3, 8'd200);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      sel = $urandom_range(19);
      if (sel < 8) begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1, 32);
      end else if (sel < 12) begin
        w = $urandom_range(1, 256);
        h = $urandom_range(1, 256);
      end else if (sel < 15) begin
        w = $urandom_range(1) ? 256 : 1;
        h = $urandom_range(1) ? 256 : 1;
      end else if (sel < 17) begin
        w = $urandom_range(257, 511);
        h = $urandom_range(1, 511);
      end else if (sel < 18) begin
        w = $urandom_range(1) ? 0 : $urandom_range(1, 511);
        h = (w == 0) ? $urandom_range(0, 511) : 0;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(200, 256);
      end
      set_frame(w, h, 1'($urandom_range(1)));
      if ($urandom_range(9) == 0) begin
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        @(negedge clk);
      end
      weff = eff_size(frame_w, FB_MAX_W);
      heff = eff_size(frame_h, FB_MAX_H);
      len = (weff == 0 || heff == 0) ? 20 : $urandom_range(50, 150);
      for (int k = 0; k < len; k++) begin
        sel = $urandom_range(99);
        if (weff * heff <= CLEAR_CAP && sel < 3) begin
          push_cmd(CMD_CLEAR, POS_W'($urandom), POS_W'($urandom), CH_W'($urandom),
                   CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        end else begin
          if (weff == 0 || heff == 0 || sel >= 90) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
          end else if (sel >= 80) begin
            x = POS_W'($urandom_range(1) ? weff + $urandom_range(3) : $urandom_range(weff - 1));
            y = POS_W'((x >= weff) ? $urandom_range(heff - 1) : heff + $urandom_range(3));
          end else begin
            x = POS_W'($urandom_range(weff - 1));
            y = POS_W'($urandom_range(heff - 1));
          end
          sel = $urandom_range(99);
          a = (sel < 15) ? 8'h00 : (sel < 30) ? 8'hFF : CH_W'($urandom_range(255));
          push_cmd(CMD_DRAW, x, y, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                   CH_W'($urandom_range(255)), a);
        end
      end
      rand_items += len;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
